// ===== rtl/cts_pkg.sv =====
`default_nettype none

package cts_pkg;

   // scanner modes; codes above MODE_WORD never occur and scan as idle
   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_TEXT,
      MODE_DQUOTE,
      MODE_SQUOTE,
      MODE_COMMENT,
      MODE_WORD
   } mode_type;

   // token kinds
   localparam logic [2:0] KIND_ITEM     = 3'd0;
   localparam logic [2:0] KIND_NAME     = 3'd1;
   localparam logic [2:0] KIND_LOOP     = 3'd2;
   localparam logic [2:0] KIND_BLOCK    = 3'd3;
   localparam logic [2:0] KIND_LEAD_CMT = 3'd4;
   localparam logic [2:0] KIND_TRAIL_CMT = 3'd5;
   localparam logic [2:0] KIND_END      = 3'd6;

   // prefix lengths and the data_ skip
   localparam logic [2:0] KW_LEN     = 3'd5;
   localparam logic [2:0] GLOBAL_LEN = 3'd7;
   localparam logic [2:0] DATA_SKIP  = 3'd5;
   localparam logic [2:0] NO_SKIP    = 3'd0;

   // characters
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DQ    = 8'h22;
   localparam logic [7:0] CH_SQ    = 8'h27;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_USCORE = 8'h5F;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_N     = 8'h6E;

   // result queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   // scanner state apart from the line counter
   typedef struct packed {
      mode_type    mode;
      logic        at_line_start;
      logic        first_on_line;
      logic        quote_pending;
      logic [2:0]  prefix_position;
      logic [3:0]  prefix_alive;
   } scan_state_type;

   typedef struct packed {
      logic [2:0] pos;
      logic [3:0] alive;
   } prefix_type;

   // one result word
   typedef struct packed {
      logic        has_byte;
      logic [7:0]  out_byte;
      logic        token_end;
      logic [2:0]  token_kind;
      logic [2:0]  skip_count;
      logic        unterminated;
      logic [31:0] line_number;
      logic        last;
   } rsp_word_type;

   function automatic logic is_white(input logic [7:0] b);
      return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
   endfunction

   function automatic logic [7:0] loop_char(input logic [2:0] p);
      logic [7:0] c;
      unique case (p)
         3'd0: c = 8'h6C;
         3'd1: c = 8'h6F;
         3'd2: c = 8'h6F;
         3'd3: c = 8'h70;
         3'd4: c = CH_USCORE;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] data_char(input logic [2:0] p);
      logic [7:0] c;
      unique case (p)
         3'd0: c = 8'h64;
         3'd1: c = 8'h61;
         3'd2: c = 8'h74;
         3'd3: c = 8'h61;
         3'd4: c = CH_USCORE;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] global_char(input logic [2:0] p);
      logic [7:0] c;
      unique case (p)
         3'd0: c = 8'h67;
         3'd1: c = 8'h6C;
         3'd2: c = 8'h6F;
         3'd3: c = 8'h62;
         3'd4: c = 8'h61;
         3'd5: c = 8'h6C;
         3'd6: c = CH_USCORE;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // advance the keyword matchers by one word character
   function automatic prefix_type prefix_feed(input logic [2:0] pos, input logic [3:0] alive,
                                              input logic [7:0] b);
      prefix_type p;
      p.pos   = pos;
      p.alive = alive;
      if (pos < KW_LEN) begin
         if (b != loop_char(pos)) p.alive[0] = 1'b0;
         if (b != data_char(pos)) p.alive[1] = 1'b0;
      end
      if (pos < GLOBAL_LEN) begin
         if (b != global_char(pos)) p.alive[2] = 1'b0;
         p.pos = pos + 3'd1;
      end
      if ((pos == 3'd0) && (b != CH_USCORE)) p.alive[3] = 1'b0;
      return p;
   endfunction

   // build a result word; fields that do not apply read as zero
   function automatic rsp_word_type mk_word(input logic has, input logic [7:0] b,
                                            input logic fin, input logic [2:0] kind,
                                            input logic [2:0] skip, input logic unterm);
      rsp_word_type w;
      w.has_byte     = has;
      w.out_byte     = has ? b : 8'h00;
      w.token_end    = fin;
      w.token_kind   = fin ? kind : 3'd0;
      w.skip_count   = fin ? skip : 3'd0;
      w.unterminated = fin & unterm;
      w.line_number  = '0;
      w.last         = 1'b0;
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/cif_token_scanner.sv =====
`default_nettype none

// CIF token scanner. Takes one text byte per input word and returns the
// token stream as result words: content bytes, token ends with their kind,
// prefix skip and unterminated flag, and the current line number. A new word
// is taken every cycle while the four-word result queue has room for two;
// results enter the queue as the byte is taken. Most bytes give at most
// one result, but a newline inside a text field or a quote that turns out not
// to close a string gives two, and end of input inside a token gives two, so
// long runs of those are paced by the result port at one word per cycle.
// The line counter is LINE_COUNT_BITS wide and wraps; rsp_line_number shows
// its low 32 bits.

module cif_token_scanner #(
   parameter int LINE_COUNT_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_has_byte,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_token_end,
   output logic [2:0]  rsp_token_kind,
   output logic [2:0]  rsp_skip_count,
   output logic        rsp_unterminated,
   output logic [31:0] rsp_line_number,
   output logic        rsp_last
);
   import cts_pkg::*;

   scan_state_type             state_ff;
   scan_state_type             state_in;
   scan_state_type             step_nxt;
   logic [LINE_COUNT_BITS-1:0] line_count_ff;
   logic [LINE_COUNT_BITS-1:0] line_count_in;
   rsp_word_type               res0;
   rsp_word_type               res1;
   rsp_word_type               wr0;
   rsp_word_type               wr1;
   rsp_word_type               rd_word;
   logic [1:0]                 num;
   logic [1:0]                 wr_num;
   logic                       new_line;
   logic                       accept;

   assign accept = req_valid & req_ready;

   cts_step u_step (
      .cur          (state_ff),
      .in_byte      (req_in_byte),
      .end_of_input (req_end_of_input),
      .nxt          (step_nxt),
      .res0         (res0),
      .res1         (res1),
      .num          (num),
      .new_line     (new_line)
   );

   // next state, line count, and the words to queue
   always_comb begin
      state_in      = accept ? step_nxt : state_ff;
      line_count_in = line_count_ff
                    + {{(LINE_COUNT_BITS-1){1'b0}}, (accept & new_line)};
      wr_num        = accept ? num : 2'd0;
      wr0             = res0;
      wr0.line_number = 32'(line_count_in);
      wr0.last        = (num == 2'd1);
      wr1             = res1;
      wr1.line_number = 32'(line_count_in);
      wr1.last        = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode            <= MODE_IDLE;
         state_ff.at_line_start   <= 1'b1;
         state_ff.first_on_line   <= 1'b1;
         state_ff.quote_pending   <= 1'b0;
         state_ff.prefix_position <= 3'd0;
         state_ff.prefix_alive    <= 4'hF;
         line_count_ff            <= '0;
      end else begin
         state_ff      <= state_in;
         line_count_ff <= line_count_in;
      end
   end

   cts_rsp_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_num   (wr_num),
      .wr0      (wr0),
      .wr1      (wr1),
      .has_room (req_ready),
      .rd_valid (rsp_valid),
      .rd_ready (rsp_ready),
      .rd_word  (rd_word)
   );

   // result port fields
   assign rsp_has_byte     = rd_word.has_byte;
   assign rsp_out_byte     = rd_word.out_byte;
   assign rsp_token_end    = rd_word.token_end;
   assign rsp_token_kind   = rd_word.token_kind;
   assign rsp_skip_count   = rd_word.skip_count;
   assign rsp_unterminated = rd_word.unterminated;
   assign rsp_line_number  = rd_word.line_number;
   assign rsp_last         = rd_word.last;

endmodule

`default_nettype wire

// ===== rtl/cts_step.sv =====
`default_nettype none

module cts_step (
   input  cts_pkg::scan_state_type cur,
   input  logic [7:0]              in_byte,
   input  logic                    end_of_input,
   output cts_pkg::scan_state_type nxt,
   output cts_pkg::rsp_word_type   res0,
   output cts_pkg::rsp_word_type   res1,
   output logic [1:0]              num,
   output logic                    new_line
);
   import cts_pkg::*;

   rsp_word_type close_w;
   rsp_word_type first_w;
   rsp_word_type cont_w;
   logic         first_v;
   logic         cont_v;
   logic         quote_done;
   logic [7:0]   q;
   prefix_type   pf_word;
   prefix_type   pf_idle;

   // quote character of the open string
   assign q = (cur.mode == MODE_DQUOTE) ? CH_DQ : CH_SQ;

   // keyword matchers: continuing a word, and starting a new one
   assign pf_word = prefix_feed(cur.prefix_position, cur.prefix_alive, in_byte);
   assign pf_idle = prefix_feed(3'd0, 4'hF, in_byte);

   // word close kind by prefix
   always_comb begin
      priority if (cur.prefix_alive[0] && (cur.prefix_position >= KW_LEN))
         close_w = mk_word(1'b0, 8'h00, 1'b1, KIND_LOOP, NO_SKIP, 1'b0);
      else if (cur.prefix_alive[1] && (cur.prefix_position >= KW_LEN))
         close_w = mk_word(1'b0, 8'h00, 1'b1, KIND_BLOCK, DATA_SKIP, 1'b0);
      else if (cur.prefix_alive[2] && (cur.prefix_position >= GLOBAL_LEN))
         close_w = mk_word(1'b0, 8'h00, 1'b1, KIND_BLOCK, NO_SKIP, 1'b0);
      else if (cur.prefix_alive[3])
         close_w = mk_word(1'b0, 8'h00, 1'b1, KIND_NAME, NO_SKIP, 1'b0);
      else
         close_w = mk_word(1'b0, 8'h00, 1'b1, KIND_ITEM, NO_SKIP, 1'b0);
   end

   // string byte: a pending quote first resolves, then the byte itself
   always_comb begin
      first_v    = 1'b0;
      first_w    = '0;
      quote_done = 1'b0;
      cont_v     = 1'b0;
      cont_w     = '0;
      if (cur.quote_pending) begin
         first_v = 1'b1;
         if ((in_byte == CH_NL) || (in_byte == CH_SPACE) || (in_byte == CH_TAB)) begin
            first_w    = mk_word(1'b1, q, 1'b1, KIND_ITEM, NO_SKIP, 1'b0);
            quote_done = 1'b1;
         end else begin
            first_w = mk_word(1'b1, q, 1'b0, KIND_ITEM, NO_SKIP, 1'b0);
         end
      end
      if (in_byte == CH_NL) begin
         cont_v = 1'b1;
         cont_w = mk_word(1'b1, q, 1'b1, KIND_ITEM, NO_SKIP, 1'b0);
      end else if (in_byte != q) begin
         cont_v = 1'b1;
         cont_w = mk_word(1'b1, in_byte, 1'b0, KIND_ITEM, NO_SKIP, 1'b0);
      end
   end

   // main scan step
   always_comb begin
      nxt      = cur;
      res0     = '0;
      res1     = '0;
      num      = 2'd0;
      new_line = 1'b0;
      if (end_of_input) begin
         // close any open token, then the end token
         num = 2'd1;
         unique case (cur.mode)
            MODE_TEXT:
               res0 = mk_word(1'b0, 8'h00, 1'b1, KIND_ITEM, NO_SKIP, 1'b1);
            MODE_DQUOTE, MODE_SQUOTE: begin
               if (cur.quote_pending)
                  res0 = mk_word(1'b1, q, 1'b1, KIND_ITEM, NO_SKIP, 1'b0);
               else
                  res0 = mk_word(1'b0, 8'h00, 1'b1, KIND_ITEM, NO_SKIP, 1'b1);
            end
            MODE_COMMENT:
               res0 = mk_word(1'b0, 8'h00, 1'b1,
                              cur.first_on_line ? KIND_LEAD_CMT : KIND_TRAIL_CMT,
                              NO_SKIP, 1'b0);
            MODE_WORD:
               res0 = close_w;
            default:
               num = 2'd0;
         endcase
         if (num == 2'd1) begin
            res1 = mk_word(1'b0, 8'h00, 1'b1, KIND_END, NO_SKIP, 1'b0);
            num  = 2'd2;
         end else begin
            res0 = mk_word(1'b0, 8'h00, 1'b1, KIND_END, NO_SKIP, 1'b0);
            num  = 2'd1;
         end
         nxt.mode          = MODE_IDLE;
         nxt.quote_pending = 1'b0;
      end else begin
         unique case (cur.mode)
            MODE_TEXT: begin
               if (cur.at_line_start && (in_byte == CH_SEMI)) begin
                  res0              = mk_word(1'b1, in_byte, 1'b1, KIND_ITEM, NO_SKIP, 1'b0);
                  num               = 2'd1;
                  nxt.mode          = MODE_IDLE;
                  nxt.at_line_start = 1'b0;
                  nxt.first_on_line = 1'b0;
               end else if (in_byte == CH_NL) begin
                  // newline in a text field goes out as backslash, n
                  res0     = mk_word(1'b1, CH_BSLASH, 1'b0, KIND_ITEM, NO_SKIP, 1'b0);
                  res1     = mk_word(1'b1, CH_N, 1'b0, KIND_ITEM, NO_SKIP, 1'b0);
                  num      = 2'd2;
                  new_line = 1'b1;
               end else begin
                  res0              = mk_word(1'b1, in_byte, 1'b0, KIND_ITEM, NO_SKIP, 1'b0);
                  num               = 2'd1;
                  nxt.at_line_start = 1'b0;
               end
            end
            MODE_DQUOTE, MODE_SQUOTE: begin
               nxt.quote_pending = 1'b0;
               if (quote_done) begin
                  res0     = first_w;
                  num      = 2'd1;
                  nxt.mode = MODE_IDLE;
                  new_line = (in_byte == CH_NL);
               end else begin
                  if (first_v) begin
                     res0 = first_w;
                     res1 = cont_w;
                     num  = cont_v ? 2'd2 : 2'd1;
                  end else begin
                     res0 = cont_w;
                     num  = cont_v ? 2'd1 : 2'd0;
                  end
                  if (in_byte == CH_NL) begin
                     nxt.mode = MODE_IDLE;
                     new_line = 1'b1;
                  end else if (in_byte == q) begin
                     nxt.quote_pending = 1'b1;
                  end
               end
            end
            MODE_COMMENT: begin
               num = 2'd1;
               if (in_byte == CH_NL) begin
                  res0     = mk_word(1'b0, 8'h00, 1'b1,
                                     cur.first_on_line ? KIND_LEAD_CMT : KIND_TRAIL_CMT,
                                     NO_SKIP, 1'b0);
                  nxt.mode = MODE_IDLE;
                  new_line = 1'b1;
               end else begin
                  res0 = mk_word(1'b1, in_byte, 1'b0, KIND_ITEM, NO_SKIP, 1'b0);
               end
            end
            MODE_WORD: begin
               num = 2'd1;
               if (is_white(in_byte)) begin
                  res0     = close_w;
                  nxt.mode = MODE_IDLE;
                  new_line = (in_byte == CH_NL);
               end else begin
                  res0                = mk_word(1'b1, in_byte, 1'b0, KIND_ITEM, NO_SKIP, 1'b0);
                  nxt.prefix_position = pf_word.pos;
                  nxt.prefix_alive    = pf_word.alive;
               end
            end
            default: begin
               // between tokens: skip blanks or open a token
               nxt.mode = MODE_IDLE;
               if (in_byte == CH_NL) begin
                  new_line = 1'b1;
               end else if (is_white(in_byte)) begin
                  num = 2'd0;
               end else begin
                  num               = 2'd1;
                  res0              = mk_word(1'b1, in_byte, 1'b0, KIND_ITEM, NO_SKIP, 1'b0);
                  nxt.at_line_start = 1'b0;
                  priority if (cur.at_line_start && (in_byte == CH_SEMI)) begin
                     nxt.mode          = MODE_TEXT;
                     nxt.first_on_line = 1'b0;
                  end else if ((in_byte == CH_DQ) || (in_byte == CH_SQ)) begin
                     nxt.mode          = (in_byte == CH_DQ) ? MODE_DQUOTE : MODE_SQUOTE;
                     nxt.quote_pending = 1'b0;
                     nxt.first_on_line = 1'b0;
                  end else if (in_byte == CH_HASH) begin
                     nxt.mode = MODE_COMMENT;
                  end else begin
                     nxt.mode            = MODE_WORD;
                     nxt.prefix_position = pf_idle.pos;
                     nxt.prefix_alive    = pf_idle.alive;
                     nxt.first_on_line   = 1'b0;
                  end
               end
            end
         endcase
      end
      // a newline restarts the line marks
      if (new_line) begin
         nxt.at_line_start = 1'b1;
         nxt.first_on_line = 1'b1;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cts_rsp_fifo.sv =====
`default_nettype none

module cts_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            wr_num,
   input  cts_pkg::rsp_word_type wr0,
   input  cts_pkg::rsp_word_type wr1,
   output logic                  has_room,
   output logic                  rd_valid,
   input  logic                  rd_ready,
   output cts_pkg::rsp_word_type rd_word
);
   import cts_pkg::*;

   rsp_word_type             entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff;
   logic [FIFO_PTR_BITS-1:0] wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] wr_ptr_nx;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff;
   logic [FIFO_CNT_BITS-1:0] count_in;
   logic                     pop;

   assign pop      = rd_valid & rd_ready;
   assign rd_valid = (count_ff != '0);
   assign rd_word  = entry_ff[rd_ptr_ff];
   // room for the two words one item can raise
   assign has_room = (count_ff <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));

   // pointer and fill count
   always_comb begin
      wr_ptr_nx = wr_ptr_ff + FIFO_PTR_BITS'(1);
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_BITS'(wr_num);
      rd_ptr_in = pop ? (rd_ptr_ff + FIFO_PTR_BITS'(1)) : rd_ptr_ff;
      count_in  = count_ff + FIFO_CNT_BITS'(wr_num) - FIFO_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // word storage
   always_ff @(posedge clock) begin
      if (wr_num != 2'd0) entry_ff[wr_ptr_ff] <= wr0;
      if (wr_num == 2'd2) entry_ff[wr_ptr_nx] <= wr1;
   end

endmodule

`default_nettype wire
